[rtl/cosine_similarity_engine_macros.svh]
// Assertion macros used by the cosine similarity engine checker.
`ifndef COSINE_SIMILARITY_ENGINE_MACROS_SVH
`define COSINE_SIMILARITY_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSE_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSE_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cse_pkg.sv]
// Shared types and constants of the cosine similarity engine.
package cse_pkg;

  localparam int ELEM_W     = 16;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int DOT_W      = 41;
  localparam int NORM_W     = 40;
  localparam int ROOT_W     = NORM_W / 2;
  localparam int DENOM_W    = 2 * ROOT_W;
  localparam int SIM_W      = 16;
  localparam int OUT_FRAC   = 15;
  localparam int ROOT_CNT_W = $clog2(ROOT_W);
  localparam int DIV_CNT_W  = $clog2(OUT_FRAC);

  localparam logic [DENOM_W-1:0]      MIN_DENOM_RST = DENOM_W'(1074);
  localparam logic signed [SIM_W-1:0] SIM_MAX = {1'b0, {(SIM_W-1){1'b1}}};
  localparam logic signed [SIM_W-1:0] SIM_MIN = {1'b1, {(SIM_W-1){1'b0}}};

  // Finished sums of one vector pair, handed from front to back.
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [NORM_W-1:0]       norm_a;
    logic [NORM_W-1:0]       norm_b;
  } vec_sums_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROOT,
    BK_MUL,
    BK_CHECK,
    BK_DIV,
    BK_DONE
  } back_state_e;

endpackage

[rtl/cse_front.sv]
// Front end: input transfer, element products and saturating accumulation.
module cse_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [cse_pkg::ELEM_W-1:0] a_element_i,
  input  logic signed [cse_pkg::ELEM_W-1:0] b_element_i,
  input  logic                              last_pair_i,
  output logic                              push_o,
  output cse_pkg::vec_sums_t                push_data_o,
  input  logic                              full_i
);
  import cse_pkg::*;

  logic                       p_valid_q, p_valid_d;
  logic                       p_last_q;
  logic signed [PROD_W-1:0]   p_ab_q, p_ab_d;
  logic [PROD_W-1:0]          p_aa_q, p_aa_d, p_bb_q, p_bb_d;
  logic signed [DOT_W-1:0]    dot_q, dot_d;
  logic [NORM_W-1:0]          na_q, na_d, nb_q, nb_d;
  logic                       accept, advance;
  logic signed [DOT_W:0]      dot_sum;
  logic [NORM_W:0]            na_sum, nb_sum;
  logic signed [DOT_W-1:0]    dot_sat;
  logic [NORM_W-1:0]          na_sat, nb_sat;

  // A last pair waits in the product stage until the queue has room.
  assign in_stall_o = p_valid_q && p_last_q && full_i;
  assign advance    = !in_stall_o;
  assign accept     = in_valid_i && advance;

  always_comb begin
    p_ab_d    = a_element_i * b_element_i;
    p_aa_d    = PROD_W'(a_element_i * a_element_i);
    p_bb_d    = PROD_W'(b_element_i * b_element_i);
    p_valid_d = advance ? accept : p_valid_q;
  end

  always_comb begin
    dot_sum = {dot_q[DOT_W-1], dot_q} + (DOT_W+1)'(p_ab_q);
    na_sum  = {1'b0, na_q} + (NORM_W+1)'(p_aa_q);
    nb_sum  = {1'b0, nb_q} + (NORM_W+1)'(p_bb_q);
    if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
      dot_sat = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
    end else begin
      dot_sat = dot_sum[DOT_W-1:0];
    end
    na_sat = na_sum[NORM_W] ? '1 : na_sum[NORM_W-1:0];
    nb_sat = nb_sum[NORM_W] ? '1 : nb_sum[NORM_W-1:0];

    push_o             = p_valid_q && p_last_q && !full_i;
    push_data_o.dot    = dot_sat;
    push_data_o.norm_a = na_sat;
    push_data_o.norm_b = nb_sat;

    dot_d = dot_q;
    na_d  = na_q;
    nb_d  = nb_q;
    if (p_valid_q && advance) begin
      if (p_last_q) begin
        dot_d = '0;
        na_d  = '0;
        nb_d  = '0;
      end else begin
        dot_d = dot_sat;
        na_d  = na_sat;
        nb_d  = nb_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_last_q  <= 1'b0;
      dot_q     <= '0;
      na_q      <= '0;
      nb_q      <= '0;
    end else begin
      p_valid_q <= p_valid_d;
      if (accept) begin
        p_last_q <= last_pair_i;
      end
      dot_q <= dot_d;
      na_q  <= na_d;
      nb_q  <= nb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_ab_q <= p_ab_d;
      p_aa_q <= p_aa_d;
      p_bb_q <= p_bb_d;
    end
  end

endmodule

[rtl/cse_queue.sv]
// Short queue of finished vector sums between front and back.
module cse_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cse_pkg::vec_sums_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               head_valid_o,
  output cse_pkg::vec_sums_t head_o
);
  import cse_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vec_sums_t        slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o       = (count_q == CNT_W'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slots_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/cse_isqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
module cse_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cse_pkg::NORM_W-1:0]  radicand_i,
  output logic                        done_o,
  output logic [cse_pkg::ROOT_W-1:0]  root_o
);
  import cse_pkg::*;

  localparam int REM_W = ROOT_W + 1;

  logic [NORM_W-1:0]     rad_q;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [ROOT_CNT_W-1:0] cnt_q;
  logic                  busy_q, done_q;
  logic [REM_W+1:0]      rem_sh, trial;
  logic                  fits;

  always_comb begin
    rem_sh = {rem_q, rad_q[NORM_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    fits   = (rem_sh >= trial);
    if (fits) begin
      rem_d  = REM_W'(rem_sh - trial);
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh[REM_W-1:0];
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ROOT_CNT_W'(ROOT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[NORM_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[rtl/cse_back.sv]
// Back end: roots, denominator, threshold check, division and result register.
module cse_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  cse_pkg::vec_sums_t                head_i,
  output logic                              pop_o,
  input  logic [cse_pkg::DENOM_W-1:0]       min_denom_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cse_pkg::SIM_W-1:0]  similarity_o,
  output logic                              degenerate_o
);
  import cse_pkg::*;

  back_state_e           state_q, state_d;
  logic                  sqrt_start, out_load, out_free;
  logic                  done_a, done_b;
  logic [ROOT_W-1:0]     root_a, root_b;
  logic                  neg_q;
  logic [DOT_W-1:0]      mag_q;
  logic [DENOM_W-1:0]    denom_q;
  logic [DENOM_W-1:0]    rem_q, rem_next;
  logic [DENOM_W:0]      rem_sh;
  logic [OUT_FRAC-1:0]   quo_q, quo_next;
  logic [DIV_CNT_W-1:0]  div_cnt_q;
  logic                  is_degen, is_sat, ge;
  logic signed [SIM_W-1:0] res_sim_q, quo_signed;
  logic                  res_deg_q;
  logic                  out_valid_q;
  logic signed [SIM_W-1:0] sim_q;
  logic                  deg_q;

  cse_isqrt u_root_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (head_i.norm_a),
    .done_o     (done_a),
    .root_o     (root_a)
  );

  cse_isqrt u_root_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (head_i.norm_b),
    .done_o     (done_b),
    .root_o     (root_b)
  );

  assign is_degen = (denom_q == '0) || (denom_q < min_denom_i);
  assign is_sat   = (mag_q >= {1'b0, denom_q});

  // Restoring division: remainder always stays below the denominator.
  always_comb begin
    rem_sh   = {rem_q, 1'b0};
    ge       = (rem_sh >= {1'b0, denom_q});
    rem_next = ge ? DENOM_W'(rem_sh - {1'b0, denom_q}) : rem_sh[DENOM_W-1:0];
    quo_next = {quo_q[OUT_FRAC-2:0], ge};
    quo_signed = neg_q ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          pop_o      = 1'b1;
          sqrt_start = 1'b1;
          state_d    = BK_ROOT;
        end
      end
      BK_ROOT: begin
        if (done_a && done_b) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL: begin
        state_d = BK_CHECK;
      end
      BK_CHECK: begin
        state_d = (is_degen || is_sat) ? BK_DONE : BK_DIV;
      end
      BK_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          neg_q <= head_i.dot[DOT_W-1];
          mag_q <= head_i.dot[DOT_W-1] ? DOT_W'(-head_i.dot) : DOT_W'(head_i.dot);
        end
      end
      BK_MUL: begin
        denom_q <= root_a * root_b;
      end
      BK_CHECK: begin
        if (is_degen) begin
          res_sim_q <= '0;
          res_deg_q <= 1'b1;
        end else if (is_sat) begin
          res_sim_q <= neg_q ? SIM_MIN : SIM_MAX;
          res_deg_q <= 1'b0;
        end else begin
          rem_q     <= mag_q[DENOM_W-1:0];
          quo_q     <= '0;
          div_cnt_q <= DIV_CNT_W'(OUT_FRAC - 1);
        end
      end
      BK_DIV: begin
        rem_q     <= rem_next;
        quo_q     <= quo_next;
        div_cnt_q <= div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          res_sim_q <= quo_signed;
          res_deg_q <= 1'b0;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      sim_q <= res_sim_q;
      deg_q <= res_deg_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign similarity_o = sim_q;
  assign degenerate_o = deg_q;

endmodule

[rtl/cosine_similarity_engine.sv]
// Top level of the streaming cosine similarity engine.
//
// Input channel: one element pair (a_element_i, b_element_i, signed Q1.15)
// per transfer, with last_pair_i marking the final pair of a vector. A
// transfer happens on a rising edge with in_valid_i high and in_stall_o low.
// The front end takes one pair per cycle while in_stall_o is low: a
// product stage, then saturating dot and norm accumulators. A last pair
// hands the three sums to a small queue (QUEUE_DEPTH vectors) and clears
// the accumulators. The back end takes one vector at a time: two iterative
// square roots run side by side, then a root multiply, a threshold check,
// restoring division (skipped for a degenerate or saturated result) and the
// load of the output register. in_stall_o rises only while a last pair
// waits for queue room.
// Output channel: similarity_o and degenerate_o transfer when out_valid_o
// is high and out_stall_i low; a stalled result holds, and the back end
// finishes the next vector behind it. Reset clears accumulators, queue and
// output valid, and sets min_denom to 1074. cfg_we_i writes cfg_wdata_i.
module cosine_similarity_engine #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cse_pkg::DENOM_W-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [cse_pkg::ELEM_W-1:0] a_element_i,
  input  logic signed [cse_pkg::ELEM_W-1:0] b_element_i,
  input  logic                              last_pair_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cse_pkg::SIM_W-1:0]  similarity_o,
  output logic                              degenerate_o
);
  import cse_pkg::*;

  logic [DENOM_W-1:0] min_denom_q;
  logic               push, full, pop, head_valid;
  vec_sums_t          push_data, head;

  // Threshold register; the user must write it only while the engine is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_denom_q <= MIN_DENOM_RST;
    end else if (cfg_we_i) begin
      min_denom_q <= cfg_wdata_i;
    end
  end

  cse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .a_element_i (a_element_i),
    .b_element_i (b_element_i),
    .last_pair_i (last_pair_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  cse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  cse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .min_denom_i  (min_denom_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .similarity_o (similarity_o),
    .degenerate_o (degenerate_o)
  );

endmodule

[rtl/cse_checker.sv]
// Port-level checker for the cosine similarity engine, bound to the top level.
`include "cosine_similarity_engine_macros.svh"

module cse_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic                              last_pair_i,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic signed [cse_pkg::SIM_W-1:0]  similarity_o,
  input  logic                              degenerate_o
);
  import cse_pkg::*;

  logic [7:0] pending_q, pending_d;
  logic       last_in, res_out;

  assign last_in = in_valid_i && !in_stall_o && last_pair_i;
  assign res_out = out_valid_o && !out_stall_i;

  always_comb begin
    pending_d = pending_q;
    if (last_in && !res_out) begin
      pending_d = pending_q + 1'b1;
    end else if (res_out && !last_in) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `CSE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(similarity_o) && $stable(degenerate_o), "stalled result changed")
  `CSE_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, out_valid_o && degenerate_o, similarity_o == '0, "degenerate result not zero")
  `CSE_ASSERT_IMP(a_no_spurious, clk_i, rst_ni, out_valid_o, pending_q != '0, "result without a finished vector")

endmodule

bind cosine_similarity_engine cse_checker u_cse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .last_pair_i  (last_pair_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .similarity_o (similarity_o),
  .degenerate_o (degenerate_o)
);

[verif/cosine_similarity_engine_test.sv]
// Self-checking testbench for the streaming cosine similarity engine.
module cosine_similarity_engine_test;
  import cse_pkg::*;

  // Receiver hold-off long enough for the result queue to fill and stall the input.
  localparam int HOLD_LEN   = 600;
  // Watchdog: cycles without any transfer before the run is declared hung.
  localparam int IDLE_LIMIT = 5000;
  // Quiet time after the last result.
  localparam int SETTLE     = 80;
  localparam int RAND_ITEMS = 240;
  localparam int PHASES     = 6;
  localparam int SAT_LEN    = 1030;
  localparam int FILL_VECS  = 20;

  localparam longint DOT_HI  = 64'sh0000_00FF_FFFF_FFFF;
  localparam longint DOT_LO  = -64'sh0000_0100_0000_0000;
  localparam longint NORM_HI = 64'sh0000_00FF_FFFF_FFFF;
  localparam logic [DENOM_W-1:0] DENOM_ALL = '1;

  // Shape of the element pairs within one random vector.
  typedef enum int {
    VEC_RANDOM,
    VEC_SMALL,
    VEC_SAME,
    VEC_OPPOSITE,
    VEC_SCALED,
    VEC_ONE_ZERO,
    VEC_EXTREME
  } vec_shape_e;

  // Predicts one similarity per vector and checks results in order.
  class similarity_scoreboard;
    typedef struct {
      logic signed [SIM_W-1:0] sim;
      logic                    degen;
    } sim_result_t;

    longint             dot_sum;
    longint             norm_a_sum;
    longint             norm_b_sum;
    logic [DENOM_W-1:0] min_denom;
    sim_result_t        pending[$];
    int                 errors;
    int                 pairs;
    int                 results;
    int                 degen_cnt;
    int                 sat_cnt;

    function new();
      dot_sum    = 0;
      norm_a_sum = 0;
      norm_b_sum = 0;
      min_denom  = MIN_DENOM_RST;
      errors     = 0;
      pairs      = 0;
      results    = 0;
      degen_cnt  = 0;
      sat_cnt    = 0;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned rem;
      longint unsigned root;
      longint unsigned probe;
      rem   = n;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem  = rem - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // Accumulate one accepted pair; a last pair closes the vector.
    function void note_pair(logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b,
                            logic last);
      longint          av;
      longint          bv;
      longint unsigned denom;
      longint unsigned mag;
      longint unsigned quot;
      sim_result_t     r;
      av = a;
      bv = b;
      pairs++;
      dot_sum    = dot_sum + av * bv;
      norm_a_sum = norm_a_sum + av * av;
      norm_b_sum = norm_b_sum + bv * bv;
      if (dot_sum > DOT_HI) dot_sum = DOT_HI;
      if (dot_sum < DOT_LO) dot_sum = DOT_LO;
      if (norm_a_sum > NORM_HI) norm_a_sum = NORM_HI;
      if (norm_b_sum > NORM_HI) norm_b_sum = NORM_HI;
      if (!last) return;

      denom = floor_sqrt(norm_a_sum) * floor_sqrt(norm_b_sum);
      if (denom == 0 || denom < min_denom) begin
        r.sim   = '0;
        r.degen = 1'b1;
        degen_cnt++;
      end else begin
        mag  = (dot_sum < 0) ? -dot_sum : dot_sum;
        quot = (mag << OUT_FRAC) / denom;
        if (dot_sum < 0) r.sim = (quot > 64'd32768) ? SIM_MIN : SIM_W'(64'd0 - quot);
        else             r.sim = (quot > 64'd32767) ? SIM_MAX : SIM_W'(quot);
        r.degen = 1'b0;
        if (r.sim == SIM_MAX || r.sim == SIM_MIN) sat_cnt++;
      end
      pending.push_back(r);
      dot_sum    = 0;
      norm_a_sum = 0;
      norm_b_sum = 0;
    endfunction

    function void check_result(logic signed [SIM_W-1:0] sim, logic degen);
      sim_result_t want;
      results++;
      if (pending.size() == 0) begin
        note_error($sformatf("unexpected result similarity=%0d degenerate=%0b", sim, degen));
        return;
      end
      want = pending.pop_front();
      if (sim !== want.sim || degen !== want.degen)
        note_error($sformatf("result %0d: expected similarity=%0d degenerate=%0b, got %0d/%0b",
                             results, want.sim, want.degen, sim, degen));
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [DENOM_W-1:0]       cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [ELEM_W-1:0] a_elem;
  logic signed [ELEM_W-1:0] b_elem;
  logic                     last_pair;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [SIM_W-1:0]  sim_out;
  logic                     degen_out;

  similarity_scoreboard sb = new();

  // Sender pacing: burst countdown and the largest gap between bursts.
  int tx_burst_left = 0;
  int tx_gap_max    = 0;
  // Receiver pacing: chance in percent that a stall run is busy, and the long hold request.
  int rx_busy_pct   = 0;
  bit hold_req      = 1'b0;
  int holds_done    = 0;
  int settings_cnt  = 0;
  int stall_seen    = 0;
  int quiet_cycles  = 0;

  cosine_similarity_engine i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .a_element_i  (a_elem),
    .b_element_i  (b_elem),
    .last_pair_i  (last_pair),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .similarity_o (sim_out),
    .degenerate_o (degen_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both channels at the rising edge; inputs only move at the falling edge,
  // so the values seen here are the ones the block sees.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_pair(a_elem, b_elem, last_pair);
    if (rst_n && out_valid && !out_stall) sb.check_result(sim_out, degen_out);
    if (rst_n && in_valid && in_stall) stall_seen++;
  end

  // Watchdog: count cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random runs of stall / no stall, or one long hold-off on request.
  initial begin
    int run_left;
    int hold_count;
    out_stall = 1'b0;
    run_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // Hold off the output long enough for the queue to fill and back up the input.
        out_stall <= 1'b1;
        hold_count = 0;
        while (hold_count < HOLD_LEN) begin
          @(negedge clk);
          hold_count++;
        end
        out_stall <= 1'b0;
        hold_req = 1'b0;
        holds_done++;
        run_left = 0;
      end else if (run_left == 0) begin
        run_left = $urandom_range(1, 16);
        out_stall <= ($urandom_range(0, 99) < rx_busy_pct);
      end else begin
        run_left--;
      end
    end
  end

  // Offer one pair and hold it until it transfers; insert a random gap between bursts.
  task automatic send_pair(input logic signed [ELEM_W-1:0] a, input logic signed [ELEM_W-1:0] b,
                           input logic last);
    int gap;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 40);
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    tx_burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    a_elem    <= a;
    b_elem    <= b;
    last_pair <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering, wait for every expected result, then let the back end settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the threshold only with the block idle.
  task automatic write_min_denom(input logic [DENOM_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.min_denom = value;
    settings_cnt++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [ELEM_W-1:0] extreme_elem();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return -16'sd1;
    endcase
  endfunction

  // Mostly short vectors, a few medium, rarely long.
  function automatic int pick_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(1, 8);
    if (roll < 98) return $urandom_range(9, 64);
    return $urandom_range(65, 300);
  endfunction

  task automatic send_vector(input int len);
    vec_shape_e               shape;
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    int                       noise;
    shape = vec_shape_e'($urandom_range(0, int'(VEC_EXTREME)));
    for (int i = 0; i < len; i++) begin
      a     = ELEM_W'($urandom());
      b     = ELEM_W'($urandom());
      noise = $urandom_range(0, 63);
      case (shape)
        VEC_SMALL: begin
          a = ELEM_W'(noise - 32);
          b = ELEM_W'(int'($urandom_range(0, 63)) - 32);
        end
        VEC_SAME:     b = a;
        VEC_OPPOSITE: b = -a;
        VEC_SCALED:   b = (a >>> 1) + ELEM_W'(noise - 32);
        VEC_ONE_ZERO: if (len[0]) a = '0; else b = '0;
        VEC_EXTREME: begin
          a = extreme_elem();
          b = extreme_elem();
        end
        default: ;
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  task automatic random_items(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = pick_len();
      send_vector(len);
      sent += len;
    end
  endtask

  initial begin
    logic [DENOM_W-1:0] thr;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    a_elem    = '0;
    b_elem    = '0;
    last_pair = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed vectors at the reset threshold: full-scale agreement and opposition
    // (+1.0 saturates, -1.0 is exact), zero denominators, tiny denominators on
    // both sides of the threshold, a mixed multi-pair vector and an orthogonal pair.
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    send_pair(16'sh7FFF, 16'sh8000, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd0, 16'sh8000, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(16'sd40, -16'sd40, 1'b1);
    send_pair(16'sd33, 16'sd32, 1'b1);
    send_pair(16'sd33, 16'sd33, 1'b1);
    send_pair(16'sd16384, 16'sd8192, 1'b0);
    send_pair(-16'sd16384, 16'sd8192, 1'b0);
    send_pair(16'sd12000, -16'sd3000, 1'b0);
    send_pair(-16'sd1, 16'sh7FFF, 1'b1);
    send_pair(16'sd10000, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd10000, 1'b1);

    // Zero threshold: a zero denominator still reports degenerate.
    write_min_denom('0);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(16'sd1, -16'sd1, 1'b1);
    send_pair(-16'sd1, 16'sd0, 1'b0);
    send_pair(16'sd0, -16'sd1, 1'b1);

    // Largest threshold: everything is degenerate.
    write_min_denom(DENOM_ALL);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);

    // Vector beyond the nominal length: the dot sum clamps at its negative limit
    // and both norms clamp at full scale instead of wrapping.
    write_min_denom(MIN_DENOM_RST);
    tx_gap_max  = 3;
    rx_busy_pct = 20;
    for (int i = 0; i < SAT_LEN; i++) send_pair(16'sh8000, 16'sh7FFF, i == SAT_LEN - 1);

    // Random phases, each under its own threshold and pacing.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       thr = MIN_DENOM_RST;
        2:       thr = '0;
        4:       thr = DENOM_ALL;
        default: thr = {8'($urandom()), 32'($urandom())} >> $urandom_range(6, 39);
      endcase
      write_min_denom(thr);
      case (p)
        0: begin tx_gap_max = 0;  rx_busy_pct = 0;  end
        1: begin tx_gap_max = 4;  rx_busy_pct = 30; end
        2: begin tx_gap_max = 12; rx_busy_pct = 60; end
        3: begin tx_gap_max = 0;  rx_busy_pct = 20; end
        4: begin tx_gap_max = 2;  rx_busy_pct = 80; end
        default: begin tx_gap_max = 8; rx_busy_pct = 40; end
      endcase
      if (p == 3) begin
        // Block the output and offer FILL_VECS short vectors, enough for the input to stall.
        hold_req = 1'b1;
        for (int v = 0; v < FILL_VECS; v++) send_vector($urandom_range(1, 2));
      end
      random_items(RAND_ITEMS / PHASES);
    end

    drain();
    $display("Run covered %0d pairs and %0d results (%0d degenerate, %0d at full scale)",
             sb.pairs, sb.results, sb.degen_cnt, sb.sat_cnt);
    $display("under %0d thresholds; input stalled %0d cycles, %0d long output hold-off(s).",
             settings_cnt, stall_seen, holds_done);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
